// ===== rtl/scanpg_pkg.sv =====
// Shared types and constants of the scan pattern phase generator.
// Holds the sequencer state type, command codes, register indexes and reset values.
// Depends on nothing.
`default_nettype none

package scanpg_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_SPD,
        S_MUL_DUR,
        S_DIVIDE,
        S_ACCUM,
        S_LERP_PAN,
        S_LERP_TILT,
        S_OUTPUT
    } t_state;

    // Fixed geometry and number formats
    localparam int STAGE_COUNT = 4;
    localparam int STAGE_W     = $clog2(STAGE_COUNT);
    localparam int SPEED_W     = 17;
    localparam int ANGLE_W     = 17;
    localparam int MS_W        = 16;
    localparam int US_W        = 16;
    localparam int LOOP_W      = 16;
    localparam int STEP_W      = 18;
    localparam int DIFF_W      = 19;
    localparam int DEN_W       = 26;

    localparam logic [SPEED_W-1:0] SPEED_FULL = 17'd65536;
    localparam logic [9:0]         US_PER_MS  = 10'd1000;
    localparam logic [LOOP_W-1:0]  LOOP_MAX   = 16'hFFFF;

    // Command codes
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_RESET     = 2'd1;
    localparam logic [1:0] CMD_SET_PHASE = 2'd2;
    localparam logic [1:0] CMD_NONE      = 2'd3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_ANGLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_ANGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_MS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CTRL   = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_SIDE_ANGLE   = 16'd11520;
    localparam logic [16:0] RST_TOP_ANGLE    = 17'sd0;
    localparam logic [16:0] RST_BOTTOM_ANGLE = -17'sd7680;
    localparam logic [15:0] RST_UPPER_MS     = 16'd1000;
    localparam logic [15:0] RST_LOWER_MS     = 16'd1000;
    localparam logic [15:0] RST_VERTICAL_MS  = 16'd500;
    localparam logic [17:0] RST_SPEED_STEP   = 18'sd3277;

endpackage

`default_nettype wire

// ===== rtl/scan_pattern_phase_generator_core.sv =====
// Top level of the scan pattern phase generator: sequencer, shared multiplier,
// restoring divider and the phase, speed and loop state.
// Depends on scanpg_pkg.
//
// Usage: configuration words arrive on the cfg channel (index, data) and are
// always taken; write them only while no command word is in work. Command words
// arrive on the in channel: tick advances the phase by elapsed time over the
// current stage duration times speed, reset restores the start phase 0.25, set
// phase loads a new phase. Each command word yields exactly one result word on
// the out channel: pan, tilt, phase, stage, applied speed and loop count.
// An advancing tick passes the speed and duration products, the restoring
// divider, which retires one quotient bit per cycle, the phase accumulation
// and the interpolation; other commands and the first tick after reset go
// straight to the interpolation. One word is in work at a time; in_ready is
// high only when the sequencer idles, so the next word waits for it.
// A result waits in the output register while the receiver stalls; the next word
// is accepted meanwhile and its result is held back until the register frees.
// Reset (synchronous, active low) restores registers and state to their defaults.
`default_nettype none

module scan_pattern_phase_generator_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [scanpg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [scanpg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // command channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_command,
    input  wire logic [15:0]                        i_elapsed_us,
    input  wire logic [16:0]                        i_requested_speed,
    input  wire logic [FRAC_BITS+1:0]               i_phase_value,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [16:0]                      o_pan,
    output logic signed [16:0]                      o_tilt,
    output logic [FRAC_BITS+1:0]                    o_phase_out,
    output logic [1:0]                              o_stage_index,
    output logic [16:0]                             o_speed_out,
    output logic [15:0]                             o_loops_done
);

    import scanpg_pkg::*;

    // Derived widths
    localparam int PHW   = FRAC_BITS + 2;                  // phase width
    localparam int NW    = FRAC_BITS + 16;                 // dividend / quotient width
    localparam int MB    = (FRAC_BITS > 16) ? FRAC_BITS : 16;
    localparam int PW    = DIFF_W + MB + 1;                // product width
    localparam int CNT_W = $clog2(NW);
    localparam int WR_W  = NW + 1 - PHW;                   // wrap count width
    localparam logic [PHW-1:0] PHASE_START = PHW'(1) << (FRAC_BITS - 2);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NW - 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic        [MS_W-1:0]   r_side_angle;
    logic signed [ANGLE_W-1:0] r_top_angle;
    logic signed [ANGLE_W-1:0] r_bottom_angle;
    logic        [MS_W-1:0]   r_upper_ms;
    logic        [MS_W-1:0]   r_lower_ms;
    logic        [MS_W-1:0]   r_vertical_ms;
    logic signed [STEP_W-1:0] r_speed_step;
    logic                     r_speed_ctrl;

    assign o_cfg_ready = 1'b1;

    // Write a register on each accepted configuration word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_angle   <= RST_SIDE_ANGLE;
            r_top_angle    <= RST_TOP_ANGLE;
            r_bottom_angle <= RST_BOTTOM_ANGLE;
            r_upper_ms     <= RST_UPPER_MS;
            r_lower_ms     <= RST_LOWER_MS;
            r_vertical_ms  <= RST_VERTICAL_MS;
            r_speed_step   <= RST_SPEED_STEP;
            r_speed_ctrl   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIDE_ANGLE:   r_side_angle   <= i_cfg_data[MS_W-1:0];
                CFG_TOP_ANGLE:    r_top_angle    <= i_cfg_data[ANGLE_W-1:0];
                CFG_BOTTOM_ANGLE: r_bottom_angle <= i_cfg_data[ANGLE_W-1:0];
                CFG_UPPER_MS:     r_upper_ms     <= i_cfg_data[MS_W-1:0];
                CFG_LOWER_MS:     r_lower_ms     <= i_cfg_data[MS_W-1:0];
                CFG_VERTICAL_MS:  r_vertical_ms  <= i_cfg_data[MS_W-1:0];
                CFG_SPEED_STEP:   r_speed_step   <= i_cfg_data[STEP_W-1:0];
                CFG_SPEED_CTRL:   r_speed_ctrl   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // State and working registers
    // ---------------------------------------------------------------
    t_state                     r_state, n_state;
    logic [PHW-1:0]             r_phase;
    logic [SPEED_W-1:0]         r_last_speed;
    logic [LOOP_W-1:0]          r_loops;
    logic                       r_started;
    logic [SPEED_W-1:0]         r_speed_app;
    logic [US_W-1:0]            r_elapsed;
    logic [DEN_W-1:0]           r_den;
    logic [DEN_W-1:0]           r_rem;
    logic [NW-1:0]              r_quo;
    logic [CNT_W-1:0]           r_count;
    logic [ANGLE_W-1:0]         r_pan_res;
    logic [ANGLE_W-1:0]         r_tilt_res;
    logic                       r_out_valid;

    logic in_accept;
    logic out_free;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    // ---------------------------------------------------------------
    // Speed: full when control is off, else slew-limited rise, drop to request, clamp to [0, full]
    // ---------------------------------------------------------------
    logic signed [DIFF_W-1:0] spd_sum;
    logic signed [DIFF_W-1:0] spd_req;
    logic signed [DIFF_W-1:0] spd_pick;
    logic        [SPEED_W-1:0] n_speed;

    always_comb begin
        spd_sum  = $signed({2'b00, r_last_speed}) + DIFF_W'(r_speed_step);
        spd_req  = $signed({2'b00, i_requested_speed});
        spd_pick = (spd_req < spd_sum) ? spd_req : spd_sum;
        priority if (!r_speed_ctrl) begin
            n_speed = SPEED_FULL;
        end else if (spd_pick < 0) begin
            n_speed = '0;
        end else if (spd_pick > $signed({2'b00, SPEED_FULL})) begin
            n_speed = SPEED_FULL;
        end else begin
            n_speed = spd_pick[SPEED_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage duration and corner geometry
    // ---------------------------------------------------------------
    logic [STAGE_W-1:0]        stage;
    logic [MS_W-1:0]           dur_ms;
    logic signed [DIFF_W-1:0]  side_pos, side_neg, top_ext, bot_ext;
    logic signed [DIFF_W-1:0]  pan_from, pan_to, tilt_from, tilt_to;

    assign stage = r_phase[PHW-1:FRAC_BITS];

    always_comb begin
        unique case (stage)
            2'd0:    dur_ms = r_upper_ms;
            2'd2:    dur_ms = r_lower_ms;
            default: dur_ms = r_vertical_ms;
        endcase
        if (dur_ms == '0) begin
            dur_ms = MS_W'(1);
        end
    end

    always_comb begin
        side_pos = $signed({3'b000, r_side_angle});
        side_neg = -side_pos;
        top_ext  = DIFF_W'(r_top_angle);
        bot_ext  = DIFF_W'(r_bottom_angle);
        unique case (stage)
            2'd0: begin
                pan_from = side_neg; pan_to = side_pos;
                tilt_from = top_ext; tilt_to = top_ext;
            end
            2'd1: begin
                pan_from = side_pos; pan_to = side_pos;
                tilt_from = top_ext; tilt_to = bot_ext;
            end
            2'd2: begin
                pan_from = side_pos; pan_to = side_neg;
                tilt_from = bot_ext; tilt_to = bot_ext;
            end
            default: begin
                pan_from = side_neg; pan_to = side_neg;
                tilt_from = bot_ext; tilt_to = top_ext;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Shared multiplier: signed operand times unsigned operand
    // ---------------------------------------------------------------
    logic signed [DIFF_W-1:0] mul_a;
    logic        [MB-1:0]     mul_b;
    logic signed [PW-1:0]     mul_p;
    logic signed [PW-1:0]     lerp_q;
    logic [31+FRAC_BITS:0]    num_wide;

    assign mul_p    = PW'(mul_a) * $signed({1'b0, mul_b});
    assign lerp_q   = mul_p >>> FRAC_BITS;
    assign num_wide = {mul_p[31:0], {FRAC_BITS{1'b0}}};

    // ---------------------------------------------------------------
    // Divider step and phase accumulation
    // ---------------------------------------------------------------
    logic [DEN_W:0]   div_trial;
    logic             div_bit;
    logic [NW:0]      acc_sum;
    logic [WR_W-1:0]  acc_wraps;
    logic [LOOP_W:0]  acc_loops;

    always_comb begin
        div_trial = {r_rem, r_quo[NW-1]};
        div_bit   = (div_trial >= {1'b0, r_den});
        acc_sum   = (NW+1)'(r_phase) + (NW+1)'(r_quo);
        acc_wraps = acc_sum[NW:PHW];
        acc_loops = (LOOP_W+1)'(r_loops) + (LOOP_W+1)'(acc_wraps);
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_command == CMD_TICK && r_started) begin
                        n_state = S_MUL_SPD;
                    end else begin
                        n_state = S_LERP_PAN;
                    end
                end
            end
            S_MUL_SPD:   n_state = S_MUL_DUR;
            S_MUL_DUR:   n_state = S_DIVIDE;
            S_DIVIDE: begin
                if (r_count == DIV_LAST) begin
                    n_state = S_ACCUM;
                end
            end
            S_ACCUM:     n_state = S_LERP_PAN;
            S_LERP_PAN:  n_state = S_LERP_TILT;
            S_LERP_TILT: n_state = S_OUTPUT;
            S_OUTPUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs (handshake and multiplier operand select)
    // ---------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_MUL_SPD: begin
                mul_a = DIFF_W'(r_speed_app);
                mul_b = MB'(r_elapsed);
            end
            S_MUL_DUR: begin
                mul_a = DIFF_W'(dur_ms);
                mul_b = MB'(US_PER_MS);
            end
            S_LERP_PAN: begin
                mul_a = pan_to - pan_from;
                mul_b = MB'(r_phase[FRAC_BITS-1:0]);
            end
            S_LERP_TILT: begin
                mul_a = tilt_to - tilt_from;
                mul_b = MB'(r_phase[FRAC_BITS-1:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // Generator state: phase, speed, loop count, started flag
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PHASE_START;
            r_last_speed <= SPEED_FULL;
            r_loops      <= '0;
            r_started    <= 1'b0;
            r_speed_app  <= '0;
        end else if (r_state == S_IDLE && in_accept) begin
            unique case (i_command)
                CMD_TICK: begin
                    // hold speed at zero on the first tick after reset
                    r_started   <= 1'b1;
                    r_speed_app <= r_started ? n_speed : '0;
                end
                CMD_RESET: begin
                    r_phase      <= PHASE_START;
                    r_last_speed <= SPEED_FULL;
                    r_loops      <= '0;
                    r_started    <= 1'b0;
                    r_speed_app  <= '0;
                end
                CMD_SET_PHASE: begin
                    r_phase     <= i_phase_value;
                    r_speed_app <= '0;
                end
                CMD_NONE: r_speed_app <= '0;
            endcase
        end else if (r_state == S_ACCUM) begin
            // advance the phase, count wraps with saturation
            r_phase      <= acc_sum[PHW-1:0];
            r_last_speed <= r_speed_app;
            r_loops      <= acc_loops[LOOP_W] ? LOOP_MAX : acc_loops[LOOP_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers: operands, divider, interpolation results
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_accept) begin
            r_elapsed <= i_elapsed_us;
        end
        unique case (r_state)
            S_MUL_SPD: begin
                // dividend: elapsed * speed * 2^FRAC_BITS / 2^16
                r_quo <= num_wide[31+FRAC_BITS:16];
                r_rem <= '0;
            end
            S_MUL_DUR: begin
                r_den   <= mul_p[DEN_W-1:0];
                r_count <= '0;
            end
            S_DIVIDE: begin
                r_rem   <= div_bit ? DEN_W'(div_trial - {1'b0, r_den})
                                   : div_trial[DEN_W-1:0];
                r_quo   <= {r_quo[NW-2:0], div_bit};
                r_count <= r_count + CNT_W'(1);
            end
            S_LERP_PAN:  r_pan_res  <= ANGLE_W'(pan_from + lerp_q[DIFF_W-1:0]);
            S_LERP_TILT: r_tilt_res <= ANGLE_W'(tilt_from + lerp_q[DIFF_W-1:0]);
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Output register: load when free, drop valid when taken
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUTPUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUTPUT && out_free) begin
            o_pan         <= r_pan_res;
            o_tilt        <= r_tilt_res;
            o_phase_out   <= r_phase;
            o_stage_index <= stage;
            o_speed_out   <= r_speed_app;
            o_loops_done  <= r_loops;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== sim/tb_scan_pattern_phase_generator_core.sv =====
// Testbench for scan_pattern_phase_generator_core: drives command and register words,
// predicts pan, tilt, phase, speed and loop count per word and checks every result word.
// Depends on scanpg_pkg and the core RTL.

module tb_scan_pattern_phase_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import scanpg_pkg::*;

    localparam int FRAC           = 16;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int SAT_TICKS      = 40;
    localparam int RAND_PHASES    = 6;
    localparam int RAND_WORDS     = 65;

    // One result word as the block should present it
    typedef struct packed {
        logic [16:0] pan;
        logic [16:0] tilt;
        logic [17:0] phase;
        logic [1:0]  stage;
        logic [16:0] speed;
        logic [15:0] loops;
    } t_pose;

    // Tracks registers and phase state, and queues the pose each command word yields
    class scan_pose_tracker;
        logic [15:0]        side_angle;
        logic signed [16:0] top_angle;
        logic signed [16:0] bottom_angle;
        logic [15:0]        upper_ms;
        logic [15:0]        lower_ms;
        logic [15:0]        vertical_ms;
        logic signed [17:0] speed_step;
        logic               speed_ctrl;

        logic [17:0] phase;
        logic [16:0] last_speed;
        logic [15:0] loops;
        logic        started;

        t_pose poses_due[$];
        int    commands;
        int    checked;
        int    mismatches;
        int    peak_loops;

        function new();
            side_angle   = RST_SIDE_ANGLE;
            top_angle    = RST_TOP_ANGLE;
            bottom_angle = RST_BOTTOM_ANGLE;
            upper_ms     = RST_UPPER_MS;
            lower_ms     = RST_LOWER_MS;
            vertical_ms  = RST_VERTICAL_MS;
            speed_step   = RST_SPEED_STEP;
            speed_ctrl   = 1'b0;
            restart();
        endfunction

        function void restart();
            phase      = 18'(1) << (FRAC - 2);
            last_speed = SPEED_FULL;
            loops      = '0;
            started    = 1'b0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [17:0] data);
            case (idx)
                CFG_SIDE_ANGLE:   side_angle   = data[15:0];
                CFG_TOP_ANGLE:    top_angle    = data[16:0];
                CFG_BOTTOM_ANGLE: bottom_angle = data[16:0];
                CFG_UPPER_MS:     upper_ms     = data[15:0];
                CFG_LOWER_MS:     lower_ms     = data[15:0];
                CFG_VERTICAL_MS:  vertical_ms  = data[15:0];
                CFG_SPEED_STEP:   speed_step   = data[17:0];
                CFG_SPEED_CTRL:   speed_ctrl   = data[0];
                default: ;
            endcase
        endfunction

        // Zero duration counts as one millisecond
        function longint stage_ms(logic [1:0] k);
            logic [15:0] d;
            case (k)
                2'd0:    d = upper_ms;
                2'd2:    d = lower_ms;
                default: d = vertical_ms;
            endcase
            return (d == 0) ? 1 : longint'(d);
        endfunction

        function void corner(logic [1:0] k, output longint pan, output longint tilt);
            longint s;
            s = longint'(side_angle);
            case (k)
                2'd0:    begin pan = -s; tilt = longint'(top_angle);    end
                2'd1:    begin pan = s;  tilt = longint'(top_angle);    end
                2'd2:    begin pan = s;  tilt = longint'(bottom_angle); end
                default: begin pan = -s; tilt = longint'(bottom_angle); end
            endcase
        endfunction

        function void note_command(logic [1:0] cmd, logic [15:0] elapsed,
                                   logic [16:0] req, logic [17:0] new_phase);
            longint      sp, num, den, sum, total;
            longint      p0, t0, p1, t1, frac;
            logic [1:0]  from_k;
            logic [16:0] applied;
            t_pose       want;
            applied = '0;
            case (cmd)
                CMD_TICK: begin
                    // advance only once a tick has been seen since reset
                    if (started) begin
                        sp = longint'(SPEED_FULL);
                        if (speed_ctrl) begin
                            sp = longint'(last_speed) + longint'(speed_step);
                            if (longint'(req) < sp) sp = longint'(req);
                            if (sp < 0) sp = 0;
                            if (sp > longint'(SPEED_FULL)) sp = longint'(SPEED_FULL);
                        end
                        num   = (longint'(elapsed) * sp) << FRAC;
                        den   = stage_ms(phase[17:16]) * 1000 * 65536;
                        sum   = longint'(phase) + num / den;
                        total = (sum >>> (FRAC + 2)) + longint'(loops);
                        phase = sum[17:0];
                        loops = (total > 65535) ? LOOP_MAX : total[15:0];
                        last_speed = sp[16:0];
                        applied    = sp[16:0];
                    end
                    started = 1'b1;
                end
                CMD_RESET:     restart();
                CMD_SET_PHASE: phase = new_phase;
                default: ;
            endcase

            // interpolate between the corner being left and the next one
            from_k = phase[17:16];
            frac   = longint'(phase[15:0]);
            corner(from_k, p0, t0);
            corner(from_k + 2'd1, p1, t1);
            p0 = p0 + (((p1 - p0) * frac) >>> FRAC);
            t0 = t0 + (((t1 - t0) * frac) >>> FRAC);
            want.pan   = p0[16:0];
            want.tilt  = t0[16:0];
            want.phase = phase;
            want.stage = from_k;
            want.speed = applied;
            want.loops = loops;
            poses_due.push_back(want);
            commands++;
            if (int'(loops) > peak_loops) peak_loops = int'(loops);
        endfunction

        function void match_field(string name, logic signed [18:0] want,
                                  logic signed [18:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_pose(t_pose got);
            t_pose want;
            if (poses_due.size() == 0) begin
                $error("result word with no command outstanding");
                mismatches++;
                return;
            end
            want = poses_due.pop_front();
            checked++;
            match_field("pan", $signed(want.pan), $signed(got.pan));
            match_field("tilt", $signed(want.tilt), $signed(got.tilt));
            match_field("phase_out", want.phase, got.phase);
            match_field("stage_index", want.stage, got.stage);
            match_field("speed_out", want.speed, got.speed);
            match_field("loops_done", want.loops, got.loops);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_command;
    logic [15:0]           i_elapsed_us;
    logic [16:0]           i_requested_speed;
    logic [FRAC+1:0]       i_phase_value;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic signed [16:0]    o_pan;
    logic signed [16:0]    o_tilt;
    logic [FRAC+1:0]       o_phase_out;
    logic [1:0]            o_stage_index;
    logic [16:0]           o_speed_out;
    logic [15:0]           o_loops_done;

    scan_pose_tracker track;
    bit idle_on = 1'b1;
    bit hold_long = 1'b0;
    int settings_count = 0;
    int quiet_cycles = 0;

    scan_pattern_phase_generator_core #(
        .FRAC_BITS(FRAC)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_elapsed_us      (i_elapsed_us),
        .i_requested_speed (i_requested_speed),
        .i_phase_value     (i_phase_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_pan             (o_pan),
        .o_tilt            (o_tilt),
        .o_phase_out       (o_phase_out),
        .o_stage_index     (o_stage_index),
        .o_speed_out       (o_speed_out),
        .o_loops_done      (o_loops_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Drop ready in short bursts, or for one long stretch on request
    initial begin : result_sink
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_out_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_long = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Check every result word taken
    always @(posedge i_clk) begin : result_check
        t_pose seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.pan   = o_pan;
            seen.tilt  = o_tilt;
            seen.phase = o_phase_out;
            seen.stage = o_stage_index;
            seen.speed = o_speed_out;
            seen.loops = o_loops_done;
            track.check_pose(seen);
        end
    end

    // Abort when no word moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** scan_pattern_phase_generator_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one command word and hold it until taken; valid stays high on return
    task automatic push_command(input logic [1:0] cmd, input logic [15:0] el,
                                input logic [16:0] req, input logic [17:0] ph);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_command         = cmd;
        i_elapsed_us      = el;
        i_requested_speed = req;
        i_phase_value     = ph;
        i_in_valid        = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        track.note_command(cmd, el, req, ph);
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every outstanding result word
    task automatic settle();
        i_in_valid = 1'b0;
        while (track.poses_due.size() != 0) @(negedge i_clk);
    endtask

    // Write all eight registers back to back; call only while the block idles
    task automatic apply_settings(input logic [15:0] side, input logic [16:0] top,
                                  input logic [16:0] bottom, input logic [15:0] upper,
                                  input logic [15:0] lower, input logic [15:0] vert,
                                  input logic [17:0] step, input logic ctrl);
        logic [17:0] regs [8];
        regs[CFG_SIDE_ANGLE]   = 18'(side);
        regs[CFG_TOP_ANGLE]    = 18'(top);
        regs[CFG_BOTTOM_ANGLE] = 18'(bottom);
        regs[CFG_UPPER_MS]     = 18'(upper);
        regs[CFG_LOWER_MS]     = 18'(lower);
        regs[CFG_VERTICAL_MS]  = 18'(vert);
        regs[CFG_SPEED_STEP]   = step;
        regs[CFG_SPEED_CTRL]   = 18'(ctrl);
        i_cfg_valid = 1'b1;
        for (int i = 0; i < 8; i++) begin
            i_cfg_index = 3'(i);
            i_cfg_data  = regs[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            track.write_reg(3'(i), regs[i]);
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
        settings_count++;
    endtask

    // Mostly short stages so the phase wraps often, now and then zero or long ones
    function automatic logic [15:0] pick_ms();
        case ($urandom_range(0, 9))
            0:             return 16'd0;
            1, 2, 3, 4, 5: return 16'($urandom_range(1, 8));
            6, 7:          return 16'($urandom_range(9, 1000));
            default:       return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [17:0] pick_step();
        if ($urandom_range(0, 2) == 0) return 18'(int'($urandom_range(0, 131072)) - 65536);
        return 18'($urandom_range(0, 8192));
    endfunction

    task automatic random_commands(input int count);
        int          pick;
        logic [1:0]  cmd;
        logic [15:0] el;
        logic [16:0] req;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72)      cmd = CMD_TICK;
            else if (pick < 86) cmd = CMD_SET_PHASE;
            else if (pick < 94) cmd = CMD_RESET;
            else                cmd = CMD_NONE;
            case ($urandom_range(0, 3))
                0:       el = 16'($urandom);
                1:       el = 16'($urandom_range(0, 255));
                default: el = 16'($urandom_range(0, 20000));
            endcase
            case ($urandom_range(0, 4))
                0:       req = 17'($urandom);
                1:       req = SPEED_FULL;
                default: req = 17'($urandom_range(0, 65536));
            endcase
            push_command(cmd, el, req, 18'($urandom));
        end
    endtask

    initial begin : stimulus
        track             = new();
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_command         = CMD_TICK;
        i_elapsed_us      = '0;
        i_requested_speed = '0;
        i_phase_value     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset registers: first tick holds the phase, then corners and edges
        push_command(CMD_TICK, 16'hFFFF, SPEED_FULL, '0);
        push_command(CMD_TICK, 16'd0, SPEED_FULL, '0);
        push_command(CMD_TICK, 16'hFFFF, 17'd0, '0);
        push_command(CMD_SET_PHASE, 16'd0, 17'd0, 18'h00000);
        push_command(CMD_SET_PHASE, 16'd0, 17'd0, 18'h3FFFF);
        push_command(CMD_TICK, 16'hFFFF, SPEED_FULL, 18'h3FFFF);
        push_command(CMD_SET_PHASE, 16'd0, 17'd0, 18'h10000);
        push_command(CMD_SET_PHASE, 16'd0, 17'd0, 18'h20000);
        push_command(CMD_SET_PHASE, 16'd0, 17'd0, 18'h30000);
        push_command(CMD_NONE, 16'hFFFF, 17'h1FFFF, 18'h3FFFF);
        push_command(CMD_RESET, 16'hFFFF, 17'h1FFFF, 18'h3FFFF);
        push_command(CMD_TICK, 16'h1234, SPEED_FULL, '0);
        settle();

        // Widest box, zero durations, full positive slew: clamp, stop, many wraps, exact 4
        apply_settings(16'd46080, -17'sd46080, 17'sd46080, 16'd0, 16'd0, 16'd0,
                       18'sd65536, 1'b1);
        push_command(CMD_TICK, 16'hFFFF, 17'h1FFFF, '0);
        push_command(CMD_TICK, 16'hFFFF, 17'd0, '0);
        push_command(CMD_TICK, 16'd1, SPEED_FULL, '0);
        push_command(CMD_SET_PHASE, 16'd0, 17'd0, 18'h3FFFF);
        push_command(CMD_TICK, 16'd1, 17'd1000, '0);
        settle();

        // Flat box, longest durations, full negative slew
        apply_settings(16'd0, 17'sd46080, -17'sd46080, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       -18'sd65536, 1'b1);
        push_command(CMD_TICK, 16'hFFFF, SPEED_FULL, '0);
        push_command(CMD_SET_PHASE, 16'd0, 17'd0, 18'h2FFFF);
        push_command(CMD_TICK, 16'hFFFF, SPEED_FULL, '0);
        settle();

        // Run many wraps per tick with the fastest stages
        apply_settings(RST_SIDE_ANGLE, RST_TOP_ANGLE, RST_BOTTOM_ANGLE, 16'd1, 16'd1, 16'd1,
                       RST_SPEED_STEP, 1'b0);
        push_command(CMD_RESET, 16'd0, 17'd0, '0);
        for (int n = 0; n < SAT_TICKS; n++)
            push_command(CMD_TICK, 16'hFFFF, 17'($urandom), 18'($urandom));
        settle();

        // Random settings and command mixes; long result stall in one, no idling in the last
        for (int p = 0; p < RAND_PHASES; p++) begin
            idle_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            apply_settings(16'($urandom_range(0, 46080)),
                           17'(int'($urandom_range(0, 92160)) - 46080),
                           17'(int'($urandom_range(0, 92160)) - 46080),
                           pick_ms(), pick_ms(), pick_ms(), pick_step(),
                           1'($urandom_range(0, 1)));
            if (p == 2) hold_long = 1'b1;
            random_commands(RAND_WORDS);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d command words and %0d result words under %0d register settings,",
                 track.commands, track.checked, settings_count);
        $display("loop count peaked at %0d, with one long result stall mid run.",
                 track.peak_loops);
        if (track.mismatches == 0 && track.poses_due.size() == 0) begin
            $display("** scan_pattern_phase_generator_core: PASSED **");
        end else begin
            $display("** scan_pattern_phase_generator_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/scanpg_pkg.sv
rtl/scan_pattern_phase_generator_core.sv
sim/tb_scan_pattern_phase_generator_core.sv
